@@ rtl/rgsf_pkg.sv @@
// ----------------------------------------------------------------------------
// rgsf_pkg
// Shared types, constants and helpers for the road graph shortest-time flood.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rgsf_pkg;

  localparam int unsigned MAX_NODES     = 1024;
  localparam int unsigned MAX_SEGMENTS  = 2048;
  localparam int unsigned SPEED_CLASSES = 16;

  localparam int unsigned NODE_W  = $clog2(MAX_NODES);
  localparam int unsigned SEG_W   = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W   = SEG_W + 1;
  localparam int unsigned HSIZE_W = NODE_W + 1;
  localparam int unsigned LEN_W   = 20;
  localparam int unsigned CLS_W   = 4;
  localparam int unsigned FLAG_W  = 8;
  localparam int unsigned COST_W  = 32;
  localparam int unsigned SPEED_W = 7;
  localparam int unsigned TIME_W  = 26;

  localparam logic [CNT_W-1:0]   LINK_NONE  = {CNT_W{1'b1}};
  localparam logic [HSIZE_W-1:0] HSLOT_NONE = {1'b1, {NODE_W{1'b0}}};
  localparam logic [COST_W-1:0]  COST_NONE  = {COST_W{1'b1}};
  localparam logic [FLAG_W-1:0]  BLOCK_FWD  = 8'h30;
  localparam logic [FLAG_W-1:0]  BLOCK_BWD  = 8'h03;

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_FLOOD = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  localparam logic [1:0] KIND_DONE  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd2;

  typedef struct packed {
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
  } seg_ends_t;

  typedef struct packed {
    logic              usable;
    logic              blk_fwd;
    logic              blk_bwd;
    logic [TIME_W-1:0] t;
  } seg_attr_t;

  typedef struct packed {
    logic [CNT_W-1:0] out_next;
    logic [CNT_W-1:0] in_next;
  } seg_links_t;

  typedef struct packed {
    logic             valid;
    logic [SEG_W-1:0] seg;
  } pred_t;

  function automatic logic [SPEED_W-1:0] speed_of(input logic [CLS_W-1:0] cls);
    logic [SPEED_W-1:0] sp;
    case (cls)
      4'd0:    sp = 7'd120;
      4'd1:    sp = 7'd120;
      4'd2:    sp = 7'd80;
      4'd3:    sp = 7'd110;
      4'd4:    sp = 7'd90;
      4'd5:    sp = 7'd80;
      4'd6:    sp = 7'd60;
      4'd7:    sp = 7'd90;
      4'd8:    sp = 7'd80;
      4'd9:    sp = 7'd70;
      4'd10:   sp = 7'd60;
      4'd11:   sp = 7'd50;
      4'd12:   sp = 7'd30;
      4'd13:   sp = 7'd10;
      4'd14:   sp = 7'd0;
      default: sp = 7'd60;
    endcase
    return sp;
  endfunction

  // heap order: lower cost first, lower node number on a tie
  function automatic logic cost_less(input logic [COST_W-1:0] ca, input logic [NODE_W-1:0] na,
                                     input logic [COST_W-1:0] cb, input logic [NODE_W-1:0] nb);
    return (ca < cb) || ((ca == cb) && (na < nb));
  endfunction

endpackage

@@ rtl/rgsf_ram.sv @@
// ----------------------------------------------------------------------------
// rgsf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgsf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/rgsf_div.sv @@
// ----------------------------------------------------------------------------
// rgsf_div
// Restoring divider, one quotient bit per cycle, for segment travel time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgsf_div
  import rgsf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [TIME_W-1:0]  dividend_i,
  input  logic [SPEED_W-1:0] divisor_i,
  output logic               busy_o,
  output logic [TIME_W-1:0]  quotient_o
);

  localparam int unsigned STEP_W = $clog2(TIME_W + 1);

  logic [SPEED_W-1:0] rem_q;
  logic [TIME_W-1:0]  quo_q;
  logic [SPEED_W-1:0] dsr_q;
  logic [STEP_W-1:0]  step_q;
  logic               busy_q;
  logic [SPEED_W:0]   trial;

  assign trial = {rem_q, quo_q[TIME_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= STEP_W'(TIME_W);
      rem_q  <= '0;
      quo_q  <= dividend_i;
      dsr_q  <= divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_q <= SPEED_W'(trial - {1'b0, dsr_q});
        quo_q <= {quo_q[TIME_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[SPEED_W-1:0];
        quo_q <= {quo_q[TIME_W-2:0], 1'b0};
      end
      step_q <= step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

@@ rtl/road_graph_shortest_time_flood_top.sv @@
// ----------------------------------------------------------------------------
// road_graph_shortest_time_flood_top
// Road graph store with shortest-time flood (heap-based) and node queries.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------
//  in      | input     | in_valid_i / in_ready_o | action, node_a, node_b, length,
//          |           |                        | road_class, one_way_flags
//  out     | output    | out_valid_o/out_ready_i | kind, cost, pred_segment, pred_valid
//
// one transaction at a time; graph, answers and heap live in single-write, single-read rams
// add: in_ready_o returns once the bit-serial divider is done and the segment is written
// query: result from the cost and predecessor rams; clear: a sweep over all node entries;
// flood: an answer sweep, then heap sift steps per level and a relax per segment visited
// after reset a sweep over all node entries clears lists and answers before in_ready_o rises
// a result waiting on out_ready_i does not block the next input transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module road_graph_shortest_time_flood_top
  import rgsf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        action_i,
  input  logic [NODE_W-1:0] node_a_i,
  input  logic [NODE_W-1:0] node_b_i,
  input  logic [LEN_W-1:0]  length_i,
  input  logic [CLS_W-1:0]  road_class_i,
  input  logic [FLAG_W-1:0] one_way_flags_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        kind_o,
  output logic [COST_W-1:0] cost_o,
  output logic [SEG_W-1:0]  pred_segment_o,
  output logic              pred_valid_o
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_ADD_RD, S_ADD_LAT, S_ADD_DIV, S_ADD_WR, S_QRY, S_FL_INIT,
    S_POP0, S_POP1, S_POP2, S_POP3, S_SD_CAP, S_SD_L, S_SD_LA, S_SD_LB, S_SD_RA,
    S_SD_RB, S_SD_MV, S_ADJ_HEAD, S_ADJ_HCAP, S_ADJ_SEG, S_ADJ_CAP, S_RX1, S_RX2,
    S_SU0, S_SU1, S_SU2, S_EMIT
  } state_e;

  state_e state_q;

  // ram ports
  logic                cst_we;
  logic [NODE_W-1:0]   cst_wa, cst_ra;
  logic [COST_W-1:0]   cst_wd, cst_rd;
  logic                prd_we;
  logic [NODE_W-1:0]   prd_wa, prd_ra;
  pred_t               prd_wd, prd_rd;
  logic                ohd_we, ihd_we;
  logic [NODE_W-1:0]   ohd_wa, ohd_ra, ihd_wa, ihd_ra;
  logic [CNT_W-1:0]    ohd_wd, ohd_rd, ihd_wd, ihd_rd;
  logic                seg_we;
  logic [SEG_W-1:0]    seg_wa, seg_ra;
  seg_ends_t           end_wd, end_rd;
  seg_attr_t           atr_wd, atr_rd;
  seg_links_t          lnk_wd, lnk_rd;
  logic                hit_we;
  logic [NODE_W-1:0]   hit_wa, hit_ra, hit_wd, hit_rd;
  logic                hsl_we;
  logic [NODE_W-1:0]   hsl_wa, hsl_ra;
  logic [HSIZE_W-1:0]  hsl_wd, hsl_rd;

  // control and working registers
  logic [NODE_W:0]     clr_idx_q;
  logic                clr_graph_q;
  logic [CNT_W-1:0]    seg_cnt_q;
  logic [HSIZE_W-1:0]  heap_size_q;
  logic [NODE_W-1:0]   na_q, nb_q, m_q, n_q, c_q, bn_q, node_q;
  logic [NODE_W-1:0]   pos_q, bpos_q;
  logic [COST_W-1:0]   base_q, ncost_q, bcost_q, nc_q;
  logic [CNT_W-1:0]    s_q, cur_s_q, ohead_q, ihead_q;
  logic                dir_q;
  logic                usable_q, blk_f_q, blk_b_q;
  logic [1:0]          res_kind_q;
  logic [COST_W-1:0]   res_cost_q;
  logic [SEG_W-1:0]    res_seg_q;
  logic                res_pv_q;
  logic                out_valid_q;
  logic [1:0]          kind_q;
  logic [COST_W-1:0]   cost_q;
  logic [SEG_W-1:0]    pred_seg_q;
  logic                pred_valid_q;

  logic                in_fire, div_start, div_busy;
  logic [TIME_W-1:0]   div_q, dividend;
  logic [NODE_W+1:0]   lchild, rchild;
  logic [NODE_W-1:0]   parent;
  logic [COST_W:0]     sum;
  logic [NODE_W-1:0]   adj_node;
  logic                adj_ok;
  action_e             act;

  assign act       = action_e'(action_i);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire   = in_valid_i && in_ready_o;
  assign div_start = in_fire && (act == ACT_ADD) && (seg_cnt_q != CNT_W'(MAX_SEGMENTS));
  // length * 36 as two shifted adds
  assign dividend  = (TIME_W'(length_i) << 5) + (TIME_W'(length_i) << 2);
  assign lchild    = {1'b0, pos_q, 1'b1};
  assign rchild    = lchild + 1'b1;
  assign parent    = NODE_W'((pos_q - 1'b1) >> 1);
  assign sum       = {1'b0, base_q} + (COST_W + 1)'(atr_rd.t);
  assign adj_node  = dir_q ? end_rd.a : end_rd.b;
  assign adj_ok    = atr_rd.usable && !(dir_q ? atr_rd.blk_bwd : atr_rd.blk_fwd);

  rgsf_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (speed_of(road_class_i)),
    .busy_o     (div_busy),
    .quotient_o (div_q)
  );

  rgsf_ram #(.WIDTH(COST_W), .DEPTH(MAX_NODES)) u_cost (
    .clk_i, .we_i(cst_we), .waddr_i(cst_wa), .wdata_i(cst_wd), .raddr_i(cst_ra),
    .rdata_o(cst_rd));
  rgsf_ram #(.WIDTH($bits(pred_t)), .DEPTH(MAX_NODES)) u_pred (
    .clk_i, .we_i(prd_we), .waddr_i(prd_wa), .wdata_i(prd_wd), .raddr_i(prd_ra),
    .rdata_o(prd_rd));
  rgsf_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_out_head (
    .clk_i, .we_i(ohd_we), .waddr_i(ohd_wa), .wdata_i(ohd_wd), .raddr_i(ohd_ra),
    .rdata_o(ohd_rd));
  rgsf_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_in_head (
    .clk_i, .we_i(ihd_we), .waddr_i(ihd_wa), .wdata_i(ihd_wd), .raddr_i(ihd_ra),
    .rdata_o(ihd_rd));
  rgsf_ram #(.WIDTH($bits(seg_ends_t)), .DEPTH(MAX_SEGMENTS)) u_seg_ends (
    .clk_i, .we_i(seg_we), .waddr_i(seg_wa), .wdata_i(end_wd), .raddr_i(seg_ra),
    .rdata_o(end_rd));
  rgsf_ram #(.WIDTH($bits(seg_attr_t)), .DEPTH(MAX_SEGMENTS)) u_seg_attr (
    .clk_i, .we_i(seg_we), .waddr_i(seg_wa), .wdata_i(atr_wd), .raddr_i(seg_ra),
    .rdata_o(atr_rd));
  rgsf_ram #(.WIDTH($bits(seg_links_t)), .DEPTH(MAX_SEGMENTS)) u_seg_links (
    .clk_i, .we_i(seg_we), .waddr_i(seg_wa), .wdata_i(lnk_wd), .raddr_i(seg_ra),
    .rdata_o(lnk_rd));
  rgsf_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_heap_items (
    .clk_i, .we_i(hit_we), .waddr_i(hit_wa), .wdata_i(hit_wd), .raddr_i(hit_ra),
    .rdata_o(hit_rd));
  rgsf_ram #(.WIDTH(HSIZE_W), .DEPTH(MAX_NODES)) u_heap_slot (
    .clk_i, .we_i(hsl_we), .waddr_i(hsl_wa), .wdata_i(hsl_wd), .raddr_i(hsl_ra),
    .rdata_o(hsl_rd));

  // ram address and write control
  always_comb begin
    cst_we = 1'b0; cst_wa = '0; cst_wd = '0; cst_ra = node_a_i;
    prd_we = 1'b0; prd_wa = '0; prd_wd = '0; prd_ra = node_a_i;
    ohd_we = 1'b0; ohd_wa = '0; ohd_wd = '0; ohd_ra = na_q;
    ihd_we = 1'b0; ihd_wa = '0; ihd_wd = '0; ihd_ra = nb_q;
    seg_we = 1'b0; seg_wa = '0; seg_ra = s_q[SEG_W-1:0];
    end_wd = '0; atr_wd = '0; lnk_wd = '0;
    hit_we = 1'b0; hit_wa = '0; hit_wd = '0; hit_ra = '0;
    hsl_we = 1'b0; hsl_wa = '0; hsl_wd = '0; hsl_ra = node_q;
    unique case (state_q)
      S_CLR: begin
        cst_we = 1'b1; cst_wa = clr_idx_q[NODE_W-1:0]; cst_wd = COST_NONE;
        prd_we = 1'b1; prd_wa = clr_idx_q[NODE_W-1:0];
        hsl_we = 1'b1; hsl_wa = clr_idx_q[NODE_W-1:0]; hsl_wd = HSLOT_NONE;
        ohd_we = clr_graph_q; ohd_wa = clr_idx_q[NODE_W-1:0]; ohd_wd = LINK_NONE;
        ihd_we = clr_graph_q; ihd_wa = clr_idx_q[NODE_W-1:0]; ihd_wd = LINK_NONE;
      end
      S_ADD_WR: begin
        seg_we = 1'b1; seg_wa = seg_cnt_q[SEG_W-1:0];
        end_wd = '{a: na_q, b: nb_q};
        atr_wd = '{usable: usable_q, blk_fwd: blk_f_q, blk_bwd: blk_b_q, t: div_q};
        lnk_wd = '{out_next: ohead_q, in_next: ihead_q};
        ohd_we = 1'b1; ohd_wa = na_q; ohd_wd = seg_cnt_q;
        ihd_we = 1'b1; ihd_wa = nb_q; ihd_wd = seg_cnt_q;
      end
      S_FL_INIT: begin
        cst_we = 1'b1; cst_wa = na_q; cst_wd = '0;
        hit_we = 1'b1; hit_wa = '0; hit_wd = na_q;
        hsl_we = 1'b1; hsl_wa = na_q; hsl_wd = '0;
      end
      S_POP1: begin
        cst_ra = hit_rd;
        hsl_we = 1'b1; hsl_wa = hit_rd; hsl_wd = HSLOT_NONE;
      end
      S_POP2: hit_ra = heap_size_q[NODE_W-1:0];
      S_POP3: begin
        hit_we = 1'b1; hit_wa = '0; hit_wd = hit_rd;
        hsl_we = 1'b1; hsl_wa = hit_rd; hsl_wd = '0;
        cst_ra = hit_rd;
      end
      S_SD_L:  hit_ra = lchild[NODE_W-1:0];
      S_SD_LA: cst_ra = hit_rd;
      S_SD_LB: hit_ra = rchild[NODE_W-1:0];
      S_SD_RA: cst_ra = hit_rd;
      S_SD_MV: begin
        hit_we = 1'b1; hit_wa = pos_q; hit_wd = (bpos_q == pos_q) ? n_q : bn_q;
        hsl_we = 1'b1; hsl_wa = hit_wd; hsl_wd = {1'b0, pos_q};
      end
      S_ADJ_HEAD: begin
        ohd_ra = m_q; ihd_ra = m_q;
      end
      S_ADJ_CAP: cst_ra = adj_node;
      S_RX1: begin
        if (nc_q < cst_rd) begin
          cst_we = 1'b1; cst_wa = node_q; cst_wd = nc_q;
          prd_we = 1'b1; prd_wa = node_q; prd_wd = '{valid: 1'b1, seg: cur_s_q[SEG_W-1:0]};
        end
      end
      S_RX2: begin
        if (hsl_rd[NODE_W] && (heap_size_q != HSIZE_W'(MAX_NODES))) begin
          hit_we = 1'b1; hit_wa = heap_size_q[NODE_W-1:0]; hit_wd = node_q;
          hsl_we = 1'b1; hsl_wa = node_q; hsl_wd = heap_size_q;
        end
      end
      S_SU0: begin
        hit_ra = parent;
        if (pos_q == '0) begin
          hit_we = 1'b1; hit_wa = '0; hit_wd = n_q;
          hsl_we = 1'b1; hsl_wa = n_q; hsl_wd = '0;
        end
      end
      S_SU1: cst_ra = hit_rd;
      S_SU2: begin
        hit_we = 1'b1; hit_wa = pos_q;
        hit_wd = cost_less(ncost_q, n_q, cst_rd, c_q) ? c_q : n_q;
        hsl_we = 1'b1; hsl_wa = hit_wd; hsl_wd = {1'b0, pos_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_idx_q   <= '0;
      clr_graph_q <= 1'b1;
      seg_cnt_q   <= '0;
      heap_size_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // the emit state loads its own result
      if (out_valid_q && out_ready_i && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLR: begin
          clr_idx_q <= clr_idx_q + 1'b1;
          if (clr_idx_q == (NODE_W + 1)'(MAX_NODES - 1)) begin
            clr_idx_q   <= '0;
            heap_size_q <= '0;
            state_q     <= clr_graph_q ? S_IDLE : S_FL_INIT;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            na_q <= node_a_i;
            nb_q <= node_b_i;
            unique case (act)
              ACT_ADD: begin
                usable_q <= (speed_of(road_class_i) != '0);
                blk_f_q  <= |(one_way_flags_i & BLOCK_FWD);
                blk_b_q  <= |(one_way_flags_i & BLOCK_BWD);
                if (seg_cnt_q == CNT_W'(MAX_SEGMENTS)) begin
                  res_kind_q <= KIND_FULL; res_cost_q <= '0;
                  res_seg_q  <= '0;        res_pv_q   <= 1'b0;
                  state_q    <= S_EMIT;
                end else begin
                  state_q <= S_ADD_RD;
                end
              end
              ACT_FLOOD: begin
                clr_graph_q <= 1'b0;
                state_q     <= S_CLR;
              end
              ACT_QUERY: state_q <= S_QRY;
              ACT_CLEAR: begin
                clr_graph_q <= 1'b1;
                seg_cnt_q   <= '0;
                state_q     <= S_CLR;
              end
              default: ;
            endcase
          end
        end
        S_ADD_RD:  state_q <= S_ADD_LAT;
        S_ADD_LAT: begin
          ohead_q <= ohd_rd;
          ihead_q <= ihd_rd;
          state_q <= S_ADD_DIV;
        end
        S_ADD_DIV: if (!div_busy) state_q <= S_ADD_WR;
        S_ADD_WR: begin
          seg_cnt_q <= seg_cnt_q + 1'b1;
          state_q   <= S_IDLE;
        end
        S_QRY: begin
          res_kind_q <= KIND_QUERY;
          res_cost_q <= cst_rd;
          res_pv_q   <= prd_rd.valid;
          res_seg_q  <= prd_rd.valid ? prd_rd.seg : '0;
          state_q    <= S_EMIT;
        end
        S_FL_INIT: begin
          heap_size_q <= HSIZE_W'(1);
          state_q     <= S_POP0;
        end
        S_POP0: begin
          if (heap_size_q == '0) begin
            res_kind_q <= KIND_DONE; res_cost_q <= '0;
            res_seg_q  <= '0;        res_pv_q   <= 1'b0;
            state_q    <= S_EMIT;
          end else begin
            state_q <= S_POP1;
          end
        end
        S_POP1: begin
          m_q         <= hit_rd;
          heap_size_q <= heap_size_q - 1'b1;
          state_q     <= S_POP2;
        end
        S_POP2: begin
          base_q  <= cst_rd;
          dir_q   <= 1'b0;
          state_q <= (heap_size_q != '0) ? S_POP3 : S_ADJ_HEAD;
        end
        S_POP3: begin
          n_q     <= hit_rd;
          pos_q   <= '0;
          state_q <= S_SD_CAP;
        end
        S_SD_CAP: begin
          ncost_q <= cst_rd;
          bcost_q <= cst_rd;
          bn_q    <= n_q;
          bpos_q  <= pos_q;
          state_q <= S_SD_L;
        end
        S_SD_L: state_q <= (lchild < (NODE_W + 2)'(heap_size_q)) ? S_SD_LA : S_SD_MV;
        S_SD_LA: begin
          c_q     <= hit_rd;
          state_q <= S_SD_LB;
        end
        S_SD_LB: begin
          if (cost_less(cst_rd, c_q, bcost_q, bn_q)) begin
            bcost_q <= cst_rd;
            bn_q    <= c_q;
            bpos_q  <= lchild[NODE_W-1:0];
          end
          state_q <= (rchild < (NODE_W + 2)'(heap_size_q)) ? S_SD_RA : S_SD_MV;
        end
        S_SD_RA: begin
          c_q     <= hit_rd;
          state_q <= S_SD_RB;
        end
        S_SD_RB: begin
          if (cost_less(cst_rd, c_q, bcost_q, bn_q)) begin
            bcost_q <= cst_rd;
            bn_q    <= c_q;
            bpos_q  <= rchild[NODE_W-1:0];
          end
          state_q <= S_SD_MV;
        end
        S_SD_MV: begin
          if (bpos_q == pos_q) begin
            state_q <= S_ADJ_HEAD;
          end else begin
            pos_q   <= bpos_q;
            bpos_q  <= bpos_q;
            bn_q    <= n_q;
            bcost_q <= ncost_q;
            state_q <= S_SD_L;
          end
        end
        S_ADJ_HEAD: state_q <= S_ADJ_HCAP;
        S_ADJ_HCAP: begin
          s_q     <= dir_q ? ihd_rd : ohd_rd;
          state_q <= S_ADJ_SEG;
        end
        S_ADJ_SEG: begin
          if (s_q < seg_cnt_q) begin
            state_q <= S_ADJ_CAP;
          end else if (!dir_q) begin
            dir_q   <= 1'b1;
            state_q <= S_ADJ_HEAD;
          end else begin
            state_q <= S_POP0;
          end
        end
        S_ADJ_CAP: begin
          cur_s_q <= s_q;
          s_q     <= dir_q ? lnk_rd.in_next : lnk_rd.out_next;
          node_q  <= adj_node;
          nc_q    <= sum[COST_W] ? COST_NONE : sum[COST_W-1:0];
          state_q <= adj_ok ? S_RX1 : S_ADJ_SEG;
        end
        S_RX1: state_q <= (nc_q < cst_rd) ? S_RX2 : S_ADJ_SEG;
        S_RX2: begin
          n_q     <= node_q;
          ncost_q <= nc_q;
          if (hsl_rd[NODE_W]) begin
            if (heap_size_q != HSIZE_W'(MAX_NODES)) begin
              pos_q       <= heap_size_q[NODE_W-1:0];
              heap_size_q <= heap_size_q + 1'b1;
              state_q     <= S_SU0;
            end else begin
              state_q <= S_ADJ_SEG;
            end
          end else begin
            pos_q   <= hsl_rd[NODE_W-1:0];
            state_q <= S_SU0;
          end
        end
        S_SU0: state_q <= (pos_q == '0) ? S_ADJ_SEG : S_SU1;
        S_SU1: begin
          c_q     <= hit_rd;
          state_q <= S_SU2;
        end
        S_SU2: begin
          if (cost_less(ncost_q, n_q, cst_rd, c_q)) begin
            pos_q   <= parent;
            state_q <= S_SU0;
          end else begin
            state_q <= S_ADJ_SEG;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            kind_q       <= res_kind_q;
            cost_q       <= res_cost_q;
            pred_seg_q   <= res_seg_q;
            pred_valid_q <= res_pv_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign cost_o         = cost_q;
  assign pred_segment_o = pred_seg_q;
  assign pred_valid_o   = pred_valid_q;

endmodule

@@ rtl/rgsf_checker.sv @@
// ----------------------------------------------------------------------------
// rgsf_checker
// Port-level checks for the road graph flood block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgsf_checker
  import rgsf_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [1:0]        action_i,
  input logic [NODE_W-1:0] node_a_i,
  input logic [NODE_W-1:0] node_b_i,
  input logic [LEN_W-1:0]  length_i,
  input logic [CLS_W-1:0]  road_class_i,
  input logic [FLAG_W-1:0] one_way_flags_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [1:0]        kind_o,
  input logic [COST_W-1:0] cost_o,
  input logic [SEG_W-1:0]  pred_segment_o,
  input logic              pred_valid_o
);

  // a result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cost_o) && $stable(kind_o))
    else $error("result changed before it was taken");

  // one transaction in flight: ready drops right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == KIND_DONE) || (kind_o == KIND_QUERY) || (kind_o == KIND_FULL))
    else $error("unknown result kind");

  a_no_pred: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_QUERY) && !pred_valid_o |-> pred_segment_o == '0)
    else $error("segment shown without predecessor");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != KIND_QUERY) |-> (cost_o == '0) && !pred_valid_o)
    else $error("status result carries payload");

endmodule

bind road_graph_shortest_time_flood_top rgsf_checker u_rgsf_checker (.*);

@@ tb/sv/tb_road_graph_shortest_time_flood_top.sv @@
// ----------------------------------------------------------------------------
// tb_road_graph_shortest_time_flood_top
// Loads small road graphs, floods them from a target and queries node answers.
// A behavioral shortest-time model predicts every result, and each result is
// compared field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_road_graph_shortest_time_flood_top;
  import rgsf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4000000;
  // transactions spent on random graphs after the table fill
  localparam int unsigned RANDOM_ITEMS = 250;
  localparam int unsigned CLASS_SPEED [16] = '{120, 120, 80, 110, 90, 80, 60, 90,
                                                80, 70, 60, 50, 30, 10, 0, 60};

  typedef struct packed {
    logic [1:0]        kind;
    logic [COST_W-1:0] cost;
    logic [SEG_W-1:0]  seg;
    logic              seg_valid;
  } answer_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        action = ACT_QUERY;
  logic [NODE_W-1:0] node_a = '0;
  logic [NODE_W-1:0] node_b = '0;
  logic [LEN_W-1:0]  seg_length = '0;
  logic [CLS_W-1:0]  road_class = '0;
  logic [FLAG_W-1:0] one_way_flags = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        kind;
  logic [COST_W-1:0] cost;
  logic [SEG_W-1:0]  pred_segment;
  logic              pred_valid;

  road_graph_shortest_time_flood_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .action_i       (action),
    .node_a_i       (node_a),
    .node_b_i       (node_b),
    .length_i       (seg_length),
    .road_class_i   (road_class),
    .one_way_flags_i(one_way_flags),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .kind_o         (kind),
    .cost_o         (cost),
    .pred_segment_o (pred_segment),
    .pred_valid_o   (pred_valid)
  );

  always #2 clk_i = ~clk_i;

  // road graph and flood answers as the block should hold them
  int unsigned seg_from [MAX_SEGMENTS];
  int unsigned seg_to   [MAX_SEGMENTS];
  int unsigned seg_len  [MAX_SEGMENTS];
  int unsigned seg_cls  [MAX_SEGMENTS];
  int unsigned seg_flg  [MAX_SEGMENTS];
  int unsigned seg_total;
  int unsigned best_cost [MAX_NODES];
  int unsigned best_seg  [MAX_NODES];
  bit          best_seg_ok [MAX_NODES];
  bit          open_node [MAX_NODES];

  answer_t     pending_answers [$];
  answer_t     want;
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned floods_sent;
  int unsigned queries_sent;
  int unsigned answers_seen;
  int unsigned full_seen;
  int unsigned cycles;
  bit          quiet;
  int unsigned stall_left;

  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void forget_answers();
    for (int i = 0; i < MAX_NODES; i++) begin
      best_cost[i] = COST_NONE;
      best_seg[i] = 0;
      best_seg_ok[i] = 1'b0;
      open_node[i] = 1'b0;
    end
  endfunction

  function automatic void try_improve(int unsigned node, int unsigned base, int unsigned s);
    int unsigned sp;
    longint unsigned t;
    longint unsigned nc;
    sp = CLASS_SPEED[seg_cls[s] & 4'hf];
    if (sp == 0) return;
    t = (longint'(seg_len[s]) * 36) / sp;
    nc = longint'(base) + t;
    if (nc > 64'hffff_ffff) nc = 64'hffff_ffff;
    if (nc >= best_cost[node]) return;
    best_cost[node] = nc[31:0];
    best_seg[node] = s;
    best_seg_ok[node] = 1'b1;
    open_node[node] = 1'b1;
  endfunction

  // dijkstra toward the target; ties go to the lower node number
  function automatic void flood_from(int unsigned target);
    int unsigned m;
    int unsigned base;
    bit          found;
    forget_answers();
    best_cost[target] = 0;
    open_node[target] = 1'b1;
    forever begin
      found = 1'b0;
      m = 0;
      for (int n = 0; n < MAX_NODES; n++)
        if (open_node[n] && (!found || best_cost[n] < best_cost[m])) begin
          m = n;
          found = 1'b1;
        end
      if (!found) break;
      open_node[m] = 1'b0;
      base = best_cost[m];
      // lists are walked newest segment first
      for (int s = int'(seg_total) - 1; s >= 0; s--)
        if (seg_from[s] == m && (seg_flg[s] & BLOCK_FWD) == 0) try_improve(seg_to[s], base, s);
      for (int s = int'(seg_total) - 1; s >= 0; s--)
        if (seg_to[s] == m && (seg_flg[s] & BLOCK_BWD) == 0) try_improve(seg_from[s], base, s);
    end
  endfunction

  function automatic void predict(action_e act, int unsigned a, int unsigned b,
                                  int unsigned len, int unsigned cls, int unsigned flg);
    answer_t ans;
    ans = '0;
    case (act)
      ACT_ADD: begin
        if (seg_total >= MAX_SEGMENTS) begin
          ans.kind = KIND_FULL;
          pending_answers.push_back(ans);
        end else begin
          seg_from[seg_total] = a;
          seg_to[seg_total] = b;
          seg_len[seg_total] = len;
          seg_cls[seg_total] = cls;
          seg_flg[seg_total] = flg;
          seg_total++;
        end
      end
      ACT_FLOOD: begin
        flood_from(a);
        ans.kind = KIND_DONE;
        pending_answers.push_back(ans);
      end
      ACT_QUERY: begin
        ans.kind = KIND_QUERY;
        ans.cost = best_cost[a];
        ans.seg_valid = best_seg_ok[a];
        ans.seg = best_seg_ok[a] ? best_seg[a][SEG_W-1:0] : '0;
        pending_answers.push_back(ans);
      end
      default: begin
        seg_total = 0;
        forget_answers();
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
    $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycles, what, got, exp);
    mismatches++;
  endtask

  // one input transaction; valid is only lowered when a gap comes first
  task automatic send_item(input action_e act, input int unsigned a, input int unsigned b,
                           input int unsigned len, input int unsigned cls,
                           input int unsigned flg);
    int unsigned gap;
    gap = quiet ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    action <= act;
    node_a <= a[NODE_W-1:0];
    node_b <= b[NODE_W-1:0];
    seg_length <= len[LEN_W-1:0];
    road_class <= cls[CLS_W-1:0];
    one_way_flags <= flg[FLAG_W-1:0];
    do @(posedge clk_i); while (!in_ready);
    // the block sees only the port widths
    predict(act, a & (MAX_NODES - 1), b & (MAX_NODES - 1), len & 32'h000f_ffff,
            cls & 32'hf, flg & 32'hff);
    items_sent++;
    if (act == ACT_FLOOD) floods_sent++;
    if (act == ACT_QUERY) queries_sent++;
  endtask

  task automatic add_seg(input int unsigned a, input int unsigned b, input int unsigned len,
                         input int unsigned cls, input int unsigned flg);
    send_item(ACT_ADD, a, b, len, cls, flg);
  endtask

  task automatic run_directed();
    send_item(ACT_QUERY, 5, 0, 0, 0, 0);
    add_seg(0, 1, 1000, 0, 8'h00);
    add_seg(1, 2, 20'hfffff, 13, 8'h30);     // start-to-end blocked
    add_seg(2, 1, 500, 14, 8'h00);           // zero speed, never usable
    add_seg(1023, 0, 0, 15, 8'h03);          // end-to-start blocked
    add_seg(3, 3, 77, 12, 8'h00);            // self loop
    add_seg(2, 3, 900, 7, 8'hff);            // blocked both ways
    add_seg(4, 1023, 7, 4, 8'hcc);
    // equal cost paths into node 8
    add_seg(5, 6, 120, 0, 8'h00);
    add_seg(5, 7, 120, 1, 8'h00);
    add_seg(6, 8, 120, 0, 8'h00);
    add_seg(7, 8, 120, 1, 8'h00);
    send_item(ACT_FLOOD, 1023, 0, 0, 0, 0);
    foreach (CLASS_SPEED[i]) if (i < 9) send_item(ACT_QUERY, i, 0, 0, 0, 0);
    send_item(ACT_QUERY, 1023, 0, 0, 0, 0);
    send_item(ACT_FLOOD, 8, 0, 0, 0, 0);
    send_item(ACT_QUERY, 5, 0, 0, 0, 0);
    send_item(ACT_CLEAR, 0, 0, 0, 0, 0);
    send_item(ACT_QUERY, 1, 0, 0, 0, 0);
  endtask

  // random graphs on small node windows, flooded and queried
  task automatic run_random_graphs();
    int unsigned span;
    int unsigned base;
    int unsigned len;
    int unsigned flg;
    int unsigned r;
    int unsigned stop_at;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      quiet = ($urandom_range(0, 4) == 0);
      span = $urandom_range(2, 24);
      base = $urandom_range(0, MAX_NODES - span);
      if ($urandom_range(0, 4) != 0) send_item(ACT_CLEAR, $urandom, 0, 0, 0, 0);
      repeat ($urandom_range(1, 40)) begin
        r = $urandom_range(0, 9);
        len = (r < 6) ? $urandom_range(0, 2000) : $urandom_range(0, 20'hfffff);
        flg = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(0, 255);
        add_seg(base + $urandom_range(0, span - 1), base + $urandom_range(0, span - 1),
                len, $urandom_range(0, 15), flg);
      end
      send_item(ACT_FLOOD, base + $urandom_range(0, span - 1), $urandom, 0, 0, 0);
      repeat ($urandom_range(4, 12))
        send_item(ACT_QUERY, base + $urandom_range(0, span - 1), $urandom, $urandom,
                  $urandom, $urandom);
      // late additions leave the earlier answers alone
      if ($urandom_range(0, 3) == 0) begin
        add_seg(base, base + span - 1, $urandom_range(0, 100), 0, 0);
        send_item(ACT_QUERY, base + span - 1, 0, 0, 0, 0);
      end
      if ($urandom_range(0, 5) == 0)
        send_item(action_e'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                  $urandom, $urandom);
    end
    quiet = 1'b0;
  endtask

  task automatic run_table_full();
    send_item(ACT_CLEAR, 0, 0, 0, 0, 0);
    for (int i = 0; i < MAX_SEGMENTS + 2; i++)
      add_seg(900 + $urandom_range(0, 31), 900 + $urandom_range(0, 31),
              $urandom_range(0, 5000), $urandom_range(0, 15),
              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : 0);
    send_item(ACT_FLOOD, 900 + $urandom_range(0, 31), 0, 0, 0, 0);
    for (int n = 900; n < 932; n++) send_item(ACT_QUERY, n, 0, 0, 0, 0);
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) stall_left = idle_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        report_mismatch("unexpected result kind", 32'(kind), 32'd0);
      end else begin
        want = pending_answers.pop_front();
        if (kind === KIND_FULL) full_seen++;
        if (kind !== want.kind) report_mismatch("kind", 32'(kind), 32'(want.kind));
        if (cost !== want.cost) report_mismatch("cost", cost, want.cost);
        if (pred_segment !== want.seg)
          report_mismatch("pred_segment", 32'(pred_segment), 32'(want.seg));
        if (pred_valid !== want.seg_valid)
          report_mismatch("pred_valid", 32'(pred_valid), 32'(want.seg_valid));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    seg_total = 0;
    forget_answers();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    run_table_full();
    run_random_graphs();
    in_valid <= 1'b0;
    while (pending_answers.size() > 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    $display("%0d transactions sent: %0d floods, %0d queries; %0d results, %0d table full",
             items_sent, floods_sent, queries_sent, answers_seen, full_seen);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
